### design/lmt_pkg.sv
package lmt_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_HBLANK_IRQ = 2'd0,
		REG_VBLANK_IRQ = 2'd1,
		REG_OAM_IRQ    = 2'd2,
		REG_COIN_IRQ   = 2'd3
	} reg_index_t;

	localparam int unsigned CountWidth = 17;
	localparam int unsigned DelayWidth = 6;

	localparam logic [CountWidth-1:0] COUNT_MAX    = 17'd131071;
	localparam logic [CountWidth-1:0] FRAME_CYCLES = 17'd70224;
	localparam logic [CountWidth-1:0] HBLANK_CYCLES = 17'd51;
	localparam logic [CountWidth-1:0] VBLANK_CYCLES = 17'd114;
	localparam logic [CountWidth-1:0] OAM_CYCLES   = 17'd20;
	localparam logic [CountWidth-1:0] XFER_CYCLES  = 17'd43;
	localparam logic [CountWidth-1:0] RENDER_AT_LINE0 = 17'd40;
	localparam logic [CountWidth-1:0] RENDER_AT_LINE  = 17'd12;
	localparam logic [DelayWidth-1:0] ON_DELAY     = 6'd61;

	localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [7:0] LAST_LINE         = 8'd153;

endpackage

### design/lmt_if.sv
interface lmt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] elapsed_cycles;
	logic       lcd_on;
	logic [7:0] line_compare;

	modport source (output valid, output elapsed_cycles, output lcd_on, output line_compare,
		input ready);
	modport sink (input valid, input elapsed_cycles, input lcd_on, input line_compare,
		output ready);
endinterface

interface lmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_number;
	logic [1:0] lcd_mode;
	logic       coincidence;
	logic       stat_request;
	logic       vblank_request;
	logic       frame_done;
	logic       render_request;
	logic       display_active;

	modport source (output valid, output line_number, output lcd_mode, output coincidence,
		output stat_request, output vblank_request, output frame_done,
		output render_request, output display_active, input ready);
	modport sink (input valid, input line_number, input lcd_mode, input coincidence,
		input stat_request, input vblank_request, input frame_done,
		input render_request, input display_active, output ready);
endinterface

### design/lcd_mode_timing_controller.sv
// LCD mode and scanline timing controller. Each item carries the machine cycles elapsed
// since the previous item, the display enable bit and the line-compare value, and yields
// exactly one result with the line, mode, coincidence flag and interrupt, frame and render
// pulses. An item is held in an input register and its result is then written to the output
// register; a new item is taken every cycle unless a result waits in the output register
// unread, and the timing state advances by at most one mode change per item through a
// single saturating add and subtract on the 17-bit cycle counter.
module lcd_mode_timing_controller (
	input  logic            clk,
	input  logic            arst_n,
	lmt_in_if.sink          in,
	lmt_out_if.source       out,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic            cfg_data
);

	logic hblank_irq_en_q, vblank_irq_en_q, oam_irq_en_q, coin_irq_en_q;

	logic       valid_s1;
	logic [7:0] elapsed_s1;
	logic       on_s1;
	logic [7:0] lyc_s1;

	logic                               run_q;
	logic [lmt_pkg::DelayWidth-1:0]     dly_q;
	logic [lmt_pkg::CountWidth-1:0]     cnt_q;
	lmt_pkg::mode_t                     mode_q;
	logic [7:0]                         line_q;
	logic                               rend_q;
	logic                               coin_q;

	logic                               n_run;
	logic [lmt_pkg::DelayWidth-1:0]     n_dly;
	logic [lmt_pkg::CountWidth-1:0]     n_cnt;
	lmt_pkg::mode_t                     n_mode;
	logic [7:0]                         n_line;
	logic                               n_rend;
	logic                               n_coin;
	logic                               n_stat, n_vbl, n_frame, n_render, do_cmp;
	logic [lmt_pkg::CountWidth:0]       sum;
	logic [7:0]                         line_inc;

	logic       out_valid_q;
	logic [7:0] line_out_q;
	logic [1:0] mode_out_q;
	logic       coin_out_q, stat_out_q, vbl_out_q, frame_out_q, render_out_q, active_out_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hblank_irq_en_q <= 1'b0;
			vblank_irq_en_q <= 1'b0;
			oam_irq_en_q    <= 1'b0;
			coin_irq_en_q   <= 1'b0;
		end else if (cfg_we) begin
			case (lmt_pkg::reg_index_t'(cfg_index))
				lmt_pkg::REG_HBLANK_IRQ: hblank_irq_en_q <= cfg_data;
				lmt_pkg::REG_VBLANK_IRQ: vblank_irq_en_q <= cfg_data;
				lmt_pkg::REG_OAM_IRQ:    oam_irq_en_q    <= cfg_data;
				lmt_pkg::REG_COIN_IRQ:   coin_irq_en_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			elapsed_s1 <= in.elapsed_cycles;
			on_s1      <= in.lcd_on;
			lyc_s1     <= in.line_compare;
		end
	end

	always_comb begin
		n_run    = run_q;
		n_dly    = dly_q;
		n_cnt    = cnt_q;
		n_mode   = mode_q;
		n_line   = line_q;
		n_rend   = rend_q;
		n_coin   = coin_q;
		n_stat   = 1'b0;
		n_vbl    = 1'b0;
		n_frame  = 1'b0;
		n_render = 1'b0;
		do_cmp   = 1'b0;

		if (on_s1) begin
			if (!run_q && dly_q == '0) begin
				n_dly = lmt_pkg::ON_DELAY;
			end
		end else if (run_q) begin
			n_run  = 1'b0;
			n_dly  = '0;
			n_cnt  = '0;
			n_mode = lmt_pkg::MODE_HBLANK;
			n_line = 8'd0;
			n_rend = 1'b0;
		end

		sum      = {1'b0, n_cnt} + {{(lmt_pkg::CountWidth - 7){1'b0}}, elapsed_s1};
		line_inc = n_line + 8'd1;

		if (n_run) begin
			n_cnt = sum[lmt_pkg::CountWidth] ? lmt_pkg::COUNT_MAX
				: sum[lmt_pkg::CountWidth-1:0];
			case (n_mode)
				lmt_pkg::MODE_HBLANK: begin
					if (n_cnt >= lmt_pkg::HBLANK_CYCLES) begin
						n_cnt  = n_cnt - lmt_pkg::HBLANK_CYCLES;
						n_line = line_inc;
						if (line_inc == lmt_pkg::FIRST_VBLANK_LINE) begin
							n_mode  = lmt_pkg::MODE_VBLANK;
							n_frame = 1'b1;
							n_vbl   = 1'b1;
							n_stat  = vblank_irq_en_q;
						end else begin
							n_mode = lmt_pkg::MODE_OAM;
							n_stat = oam_irq_en_q;
						end
					end
				end
				lmt_pkg::MODE_VBLANK: begin
					if (n_cnt >= lmt_pkg::VBLANK_CYCLES) begin
						n_cnt  = n_cnt - lmt_pkg::VBLANK_CYCLES;
						n_line = line_inc;
						if (line_inc > lmt_pkg::LAST_LINE) begin
							n_mode = lmt_pkg::MODE_OAM;
							n_line = 8'd0;
							n_stat = oam_irq_en_q;
						end
					end
				end
				lmt_pkg::MODE_OAM: begin
					if (n_cnt >= lmt_pkg::OAM_CYCLES) begin
						n_cnt  = n_cnt - lmt_pkg::OAM_CYCLES;
						n_mode = lmt_pkg::MODE_XFER;
						n_rend = 1'b0;
					end
				end
				default: begin
					if (!n_rend && n_cnt >= ((n_line != 8'd0) ? lmt_pkg::RENDER_AT_LINE
							: lmt_pkg::RENDER_AT_LINE0)) begin
						n_rend   = 1'b1;
						n_render = 1'b1;
					end
					if (n_cnt >= lmt_pkg::XFER_CYCLES) begin
						n_cnt  = n_cnt - lmt_pkg::XFER_CYCLES;
						n_mode = lmt_pkg::MODE_HBLANK;
						n_stat = hblank_irq_en_q;
					end
				end
			endcase
			do_cmp = 1'b1;
		end else if (n_dly != '0) begin
			if (elapsed_s1 >= {{(8 - lmt_pkg::DelayWidth){1'b0}}, n_dly}) begin
				n_cnt  = {{(lmt_pkg::CountWidth - 8){1'b0}},
					elapsed_s1 - {{(8 - lmt_pkg::DelayWidth){1'b0}}, n_dly}};
				n_run  = 1'b1;
				n_dly  = '0;
				n_line = 8'd0;
				n_mode = lmt_pkg::MODE_HBLANK;
				n_rend = 1'b0;
				do_cmp = 1'b1;
			end else begin
				n_dly = n_dly - elapsed_s1[lmt_pkg::DelayWidth-1:0];
			end
		end else begin
			n_cnt = sum[lmt_pkg::CountWidth] ? lmt_pkg::COUNT_MAX
				: sum[lmt_pkg::CountWidth-1:0];
			if (n_cnt >= lmt_pkg::FRAME_CYCLES) begin
				n_cnt   = n_cnt - lmt_pkg::FRAME_CYCLES;
				n_frame = 1'b1;
			end
		end

		if (do_cmp) begin
			n_coin = (n_line == lyc_s1);
			if (n_coin && coin_irq_en_q) begin
				n_stat = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b1;
			dly_q  <= '0;
			cnt_q  <= '0;
			mode_q <= lmt_pkg::MODE_VBLANK;
			line_q <= lmt_pkg::FIRST_VBLANK_LINE;
			rend_q <= 1'b0;
			coin_q <= 1'b0;
		end else if (advance) begin
			run_q  <= n_run;
			dly_q  <= n_dly;
			cnt_q  <= n_cnt;
			mode_q <= n_mode;
			line_q <= n_line;
			rend_q <= n_rend;
			coin_q <= n_coin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_out_q   <= n_line;
			mode_out_q   <= 2'(n_mode);
			coin_out_q   <= n_coin;
			stat_out_q   <= n_stat;
			vbl_out_q    <= n_vbl;
			frame_out_q  <= n_frame;
			render_out_q <= n_render;
			active_out_q <= n_run;
		end
	end

	assign out.valid          = out_valid_q;
	assign out.line_number    = line_out_q;
	assign out.lcd_mode       = mode_out_q;
	assign out.coincidence    = coin_out_q;
	assign out.stat_request   = stat_out_q;
	assign out.vblank_request = vbl_out_q;
	assign out.frame_done     = frame_out_q;
	assign out.render_request = render_out_q;
	assign out.display_active = active_out_q;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.line_number <= lmt_pkg::LAST_LINE)
		else $error("line number out of range");

	a_off_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.display_active) |->
			(out.line_number == 8'd0 && out.lcd_mode == 2'(lmt_pkg::MODE_HBLANK)))
		else $error("display off but not parked on line 0 in hblank");

	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.vblank_request) |->
			(out.frame_done && out.line_number == lmt_pkg::FIRST_VBLANK_LINE
			&& out.lcd_mode == 2'(lmt_pkg::MODE_VBLANK)))
		else $error("vblank request without entry to vertical blank");

	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.render_request) |->
			(out.lcd_mode == 2'(lmt_pkg::MODE_XFER)
			|| out.lcd_mode == 2'(lmt_pkg::MODE_HBLANK)))
		else $error("render pulse outside pixel transfer");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(elapsed_s1) && $stable(cnt_q)))
		else $error("stalled item or timing state changed");

endmodule

### bench/lcd_timing_checker.sv
module lcd_timing_checker (
	input  logic        clk,
	input  logic        arst_n,
	lmt_in_if           item_ch,
	lmt_out_if          result_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_results,
	output int unsigned results_checked,
	output int unsigned frame_count,
	output int unsigned render_count,
	output int unsigned stat_count,
	output int unsigned vblank_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HblankLen    = 51;
	localparam int unsigned VblankLen    = 114;
	localparam int unsigned OamLen       = 20;
	localparam int unsigned XferLen      = 43;
	localparam int unsigned RenderLine0  = 40;
	localparam int unsigned RenderOther  = 12;
	localparam int unsigned FreeFrameLen = 70224;
	localparam int unsigned TurnOnWait   = 61;
	localparam int unsigned CountCeiling = 131071;
	localparam int unsigned VblankLine   = 144;
	localparam int unsigned LastLine     = 153;

	typedef struct packed {
		logic [7:0]      line;
		lmt_pkg::mode_t  mode;
		logic            coin;
		logic            stat;
		logic            vbl;
		logic            frame;
		logic            render;
		logic            active;
	} lcd_report_t;

	lcd_report_t expected_reports[$];

	logic            en_hblank, en_vblank, en_oam, en_coin;
	logic            running;
	logic [8:0]      on_wait;
	logic [16:0]     cycle_cnt;
	lmt_pkg::mode_t  cur_mode;
	logic [7:0]      cur_line;
	logic            rendered;
	logic            coin_flag;

	function automatic void park_timing();
		running = 1'b1;
		rendered = 1'b0;
		cur_line = 8'(VblankLine);
		cycle_cnt = '0;
		cur_mode = lmt_pkg::MODE_VBLANK;
		on_wait = '0;
	endfunction

	function automatic void add_cycles(input logic [7:0] cycles);
		logic [17:0] total;
		total = {1'b0, cycle_cnt} + 18'(cycles);
		cycle_cnt = (total > CountCeiling) ? 17'(CountCeiling) : total[16:0];
	endfunction

	function automatic logic compare_line(input logic [7:0] lyc);
		coin_flag = (cur_line == lyc);
		return coin_flag & en_coin;
	endfunction

	function automatic lcd_report_t advance_timing(input logic [7:0] cycles, input logic on,
			input logic [7:0] lyc);
		lcd_report_t r;
		logic [16:0] over;
		r = '0;
		if (on) begin
			if (!running && on_wait == 0)
				on_wait = 9'(TurnOnWait);
		end else if (running) begin
			park_timing();
			cur_line = '0;
			cur_mode = lmt_pkg::MODE_HBLANK;
			running = 1'b0;
		end

		if (running) begin
			add_cycles(cycles);
			case (cur_mode)
				lmt_pkg::MODE_HBLANK: begin
					if (cycle_cnt >= HblankLen) begin
						cycle_cnt = cycle_cnt - 17'(HblankLen);
						cur_line = cur_line + 8'd1;
						if (cur_line == VblankLine) begin
							cur_mode = lmt_pkg::MODE_VBLANK;
							r.frame = 1'b1;
							r.vbl = 1'b1;
							if (en_vblank)
								r.stat = 1'b1;
						end else begin
							cur_mode = lmt_pkg::MODE_OAM;
							if (en_oam)
								r.stat = 1'b1;
						end
					end
				end
				lmt_pkg::MODE_VBLANK: begin
					if (cycle_cnt >= VblankLen) begin
						cycle_cnt = cycle_cnt - 17'(VblankLen);
						cur_line = cur_line + 8'd1;
						if (cur_line > LastLine) begin
							cur_mode = lmt_pkg::MODE_OAM;
							cur_line = '0;
							if (en_oam)
								r.stat = 1'b1;
						end
					end
				end
				lmt_pkg::MODE_OAM: begin
					if (cycle_cnt >= OamLen) begin
						cycle_cnt = cycle_cnt - 17'(OamLen);
						cur_mode = lmt_pkg::MODE_XFER;
						rendered = 1'b0;
					end
				end
				default: begin
					if (!rendered && cycle_cnt >= ((cur_line != 0) ? RenderOther : RenderLine0)) begin
						rendered = 1'b1;
						r.render = 1'b1;
					end
					if (cycle_cnt >= XferLen) begin
						cycle_cnt = cycle_cnt - 17'(XferLen);
						cur_mode = lmt_pkg::MODE_HBLANK;
						if (en_hblank)
							r.stat = 1'b1;
					end
				end
			endcase
			if (compare_line(lyc))
				r.stat = 1'b1;
		end else if (on_wait != 0) begin
			if (cycles >= on_wait) begin
				over = 17'(cycles - on_wait);
				park_timing();
				cycle_cnt = over;
				cur_line = '0;
				cur_mode = lmt_pkg::MODE_HBLANK;
				if (compare_line(lyc))
					r.stat = 1'b1;
			end else begin
				on_wait = on_wait - 9'(cycles);
			end
		end else begin
			add_cycles(cycles);
			if (cycle_cnt >= FreeFrameLen) begin
				cycle_cnt = cycle_cnt - 17'(FreeFrameLen);
				r.frame = 1'b1;
			end
		end

		r.line = cur_line;
		r.mode = cur_mode;
		r.coin = coin_flag;
		r.active = running;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcd_report_t want;
		if (!arst_n) begin
			expected_reports.delete();
			en_hblank = 1'b0;
			en_vblank = 1'b0;
			en_oam = 1'b0;
			en_coin = 1'b0;
			park_timing();
			coin_flag = 1'b0;
			fail_count = 0;
			results_checked = 0;
			frame_count = 0;
			render_count = 0;
			stat_count = 0;
			vblank_count = 0;
			pending_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lmt_pkg::REG_HBLANK_IRQ: en_hblank = cfg_data;
					lmt_pkg::REG_VBLANK_IRQ: en_vblank = cfg_data;
					lmt_pkg::REG_OAM_IRQ:    en_oam = cfg_data;
					lmt_pkg::REG_COIN_IRQ:   en_coin = cfg_data;
					default: ;
				endcase
			end

			if (item_ch.valid && item_ch.ready)
				expected_reports.push_back(advance_timing(item_ch.elapsed_cycles,
					item_ch.lcd_on, item_ch.line_compare));

			if (result_ch.valid && result_ch.ready) begin
				if (expected_reports.size() == 0) begin
					fail_count++;
					$display("%0t: result with no item pending, expected none, actual line %0d mode %0d",
						$time, result_ch.line_number, result_ch.lcd_mode);
				end else begin
					want = expected_reports.pop_front();
					check_field("line_number", want.line, result_ch.line_number);
					check_field("lcd_mode", 8'(want.mode), 8'(result_ch.lcd_mode));
					check_field("coincidence", 8'(want.coin), 8'(result_ch.coincidence));
					check_field("stat_request", 8'(want.stat), 8'(result_ch.stat_request));
					check_field("vblank_request", 8'(want.vbl),
						8'(result_ch.vblank_request));
					check_field("frame_done", 8'(want.frame), 8'(result_ch.frame_done));
					check_field("render_request", 8'(want.render),
						8'(result_ch.render_request));
					check_field("display_active", 8'(want.active),
						8'(result_ch.display_active));
					results_checked++;
					frame_count += want.frame;
					render_count += want.render;
					stat_count += want.stat;
					vblank_count += want.vbl;
				end
			end

			pending_results <= expected_reports.size();
		end
	end

endmodule

### bench/lcd_mode_timing_controller_tb.sv
module lcd_mode_timing_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PhaseItems     = 40;
	localparam int FloodItems     = 720;
	localparam int FreeFrameItems = 300;
	localparam int LongHoldCycles = 80;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic        cfg_data;

	lmt_in_if  item_ch();
	lmt_out_if result_ch();

	int unsigned fail_count, pending_results, results_checked;
	int unsigned frame_count, render_count, stat_count, vblank_count;

	int src_idle_pct;
	int sink_idle_pct;
	bit long_hold_wanted;
	int items_sent;
	int settings_used;

	lcd_mode_timing_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (item_ch),
		.out       (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcd_timing_checker timing_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_ch         (item_ch),
		.result_ch       (result_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.frame_count     (frame_count),
		.render_count    (render_count),
		.stat_count      (stat_count),
		.vblank_count    (vblank_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** lcd_mode_timing_controller: FAILED **");
		$finish;
	end

	initial begin
		int hold_left;
		bit long_hold_taken;
		hold_left = 0;
		long_hold_taken = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_wanted && !long_hold_taken) begin
				long_hold_taken = 1'b1;
				hold_left = LongHoldCycles - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [7:0] cycles, input logic on, input logic [7:0] lyc);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.elapsed_cycles <= cycles;
		item_ch.lcd_on <= on;
		item_ch.line_compare <= lyc;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic wait_quiet();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input lmt_pkg::reg_index_t idx, input logic value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_enables(input logic [3:0] en);
		write_reg(lmt_pkg::REG_HBLANK_IRQ, en[0]);
		write_reg(lmt_pkg::REG_VBLANK_IRQ, en[1]);
		write_reg(lmt_pkg::REG_OAM_IRQ, en[2]);
		write_reg(lmt_pkg::REG_COIN_IRQ, en[3]);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_cycles();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'($urandom_range(30));
		else if (r < 85)
			return 8'($urandom_range(120, 31));
		return 8'($urandom_range(255, 121));
	endfunction

	function automatic logic [7:0] pick_compare(input logic [7:0] base);
		return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : base;
	endfunction

	// Mostly long stretches with the display on, so the line walk gets deep, mixed with
	// short off periods and stretches where the enable bit flips at random.
	task automatic random_segment();
		int unsigned kind;
		int unsigned len;
		logic [7:0] base;
		kind = $urandom_range(99);
		base = 8'($urandom_range(153));
		if (kind < 55) begin
			len = $urandom_range(300, 20);
			repeat (len) send_item(pick_cycles(), 1'b1, pick_compare(base));
		end else if (kind < 75) begin
			len = $urandom_range(8, 1);
			repeat (len) send_item(8'($urandom_range(255)), 1'b0, pick_compare(base));
		end else begin
			len = $urandom_range(30, 5);
			repeat (len) send_item(pick_cycles(), ($urandom_range(9) < 7), pick_compare(base));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.elapsed_cycles <= '0;
		item_ch.lcd_on <= 1'b0;
		item_ch.line_compare <= '0;
		cfg_we <= 1'b0;
		cfg_index <= lmt_pkg::REG_HBLANK_IRQ;
		cfg_data <= 1'b0;
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		long_hold_wanted <= 1'b0;
		items_sent = 0;
		settings_used = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_enables(4'hF);
		send_item(8'd0, 1'b1, 8'd144);
		repeat (10) send_item(8'd114, 1'b1, 8'd0);
		send_item(8'd20, 1'b1, 8'd0);
		send_item(8'd39, 1'b1, 8'd0);
		send_item(8'd1, 1'b1, 8'd0);
		send_item(8'd3, 1'b1, 8'd0);
		send_item(8'd51, 1'b1, 8'd1);
		send_item(8'd20, 1'b1, 8'd1);
		send_item(8'd43, 1'b1, 8'd1);
		send_item(8'd255, 1'b0, 8'd200);
		send_item(8'd0, 1'b0, 8'd200);
		send_item(8'd10, 1'b1, 8'd7);
		send_item(8'd20, 1'b0, 8'd7);
		send_item(8'd31, 1'b1, 8'd0);
		send_item(8'd0, 1'b0, 8'd255);
		send_item(8'd255, 1'b1, 8'd0);

		for (int ph = 0; ph < 6; ph++) begin
			int phase_start;
			wait_quiet();
			case (ph)
				0: set_enables(4'h0);
				5: set_enables(4'hF);
				default: set_enables(4'($urandom_range(15)));
			endcase
			src_idle_pct = (ph < 2) ? 23 : ((ph < 4) ? 59 : 0);
			sink_idle_pct <= (ph < 2) ? 59 : ((ph < 4) ? 23 : 0);
			if (ph == 1)
				repeat (FreeFrameItems)
					send_item(8'($urandom_range(255, 240)), 1'b0, 8'($urandom_range(255)));
			if (ph == 4)
				long_hold_wanted <= 1'b1;
			if (ph == 5)
				repeat (FloodItems)
					send_item(8'($urandom_range(255, 250)), 1'b1, 8'($urandom_range(153)));
			phase_start = items_sent;
			while (items_sent - phase_start < PhaseItems)
				random_segment();
		end

		wait_quiet();
		$display("Run: %0d items under %0d interrupt enable settings, %0d results compared.",
			items_sent, settings_used, results_checked);
		$display("Seen: %0d frame ends, %0d vblank and %0d STAT requests, %0d render pulses.",
			frame_count, vblank_count, stat_count, render_count);
		if (fail_count == 0 && pending_results == 0)
			$display("** lcd_mode_timing_controller: PASSED **");
		else
			$display("** lcd_mode_timing_controller: FAILED **");
		$finish;
	end

endmodule
